[hdl/rsos_pkg.sv]
package rsos_pkg;

    localparam int ADDR_BITS_DEF = 24;
    localparam int ADDR_W        = 24;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic [3:0] OP_INS        = 4'd0;
    localparam logic [3:0] OP_OUTS       = 4'd1;
    localparam logic [3:0] OP_MOVS       = 4'd2;
    localparam logic [3:0] OP_LODS       = 4'd3;
    localparam logic [3:0] OP_STOS       = 4'd4;
    localparam logic [3:0] OP_REPE_CMPS  = 4'd5;
    localparam logic [3:0] OP_REPNE_CMPS = 4'd6;
    localparam logic [3:0] OP_REPE_SCAS  = 4'd7;
    localparam logic [3:0] OP_REPNE_SCAS = 4'd8;

    localparam logic OPER_START   = 1'b0;
    localparam logic OPER_ELEMENT = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [3:0]  string_op;
        logic        word_size;
        logic        direction_down;
        logic [15:0] start_count;
        logic [15:0] source_offset;
        logic [15:0] dest_offset;
        logic [23:0] source_base;
        logic [23:0] dest_base;
        logic [15:0] first_data;
        logic [15:0] second_data;
        logic        budget_spent;
    } in_item_t;

    typedef struct packed {
        logic [23:0] source_address;
        logic [23:0] dest_address;
        logic [15:0] store_data;
        logic        store_enable;
        logic [7:0]  status_flags;
        logic        overflow_flag;
        logic [15:0] count_left;
        logic [15:0] source_offset_now;
        logic [15:0] dest_offset_now;
        logic [15:0] accumulator_now;
        logic        finished;
        logic        suspended;
    } out_item_t;

    // classified beat passed from front to back
    typedef struct packed {
        logic     is_start;
        logic     zero_run;
        in_item_t item;
    } queue_item_t;

endpackage

[hdl/rsos_front.sv]
module rsos_front (
    input  rsos_pkg::in_item_t    item,
    output rsos_pkg::queue_item_t entry
);
    import rsos_pkg::*;

    always_comb
    begin
        entry.item     = item;
        entry.is_start = (item.operation == OPER_START);
        // empty count or unknown op ends at once
        entry.zero_run = (item.start_count == 16'd0) || (item.string_op > OP_REPNE_SCAS);
    end

endmodule

[hdl/rsos_queue.sv]
module rsos_queue #(
    parameter int DEPTH = rsos_pkg::QUEUE_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  rsos_pkg::queue_item_t  push_data,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output rsos_pkg::queue_item_t  head_data
);
    import rsos_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[hdl/rsos_back.sv]
module rsos_back #(
    parameter int ADDR_BITS = rsos_pkg::ADDR_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  rsos_pkg::queue_item_t head_data,
    output logic                  pop,
    output logic                  result_valid,
    input  logic                  result_stall,
    output rsos_pkg::out_item_t   result
);
    import rsos_pkg::*;

    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ? {ADDR_W{1'b1}}
                                              : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    logic        busy_reg, busy_next;
    logic [3:0]  op_kind_reg, op_kind_next;
    logic        word_mode_reg, word_mode_next;
    logic        going_down_reg, going_down_next;
    logic [15:0] count_reg, count_next;
    logic [15:0] src_index_reg, src_index_next;
    logic [15:0] dst_index_reg, dst_index_next;
    logic [23:0] src_segment_reg, src_segment_next;
    logic [23:0] dst_segment_reg, dst_segment_next;
    logic [15:0] acc_reg, acc_next;

    logic        result_valid_reg, result_valid_next;
    out_item_t   result_reg, result_next;

    logic        produce;
    logic        is_cmp, is_scas, is_repe;
    logic [15:0] d1, d2, step, cmp_a, store;
    logic [16:0] diff;
    logic        st_en, fin, susp, ovf;
    logic        cf, pf, af, zf, sf;
    logic [7:0]  flags;
    logic [24:0] src_sum, dst_sum;

    assign produce = head_data.is_start || busy_reg;
    assign pop     = head_valid && (!result_valid_reg || !result_stall);

    always_comb
    begin
        busy_next        = busy_reg;
        op_kind_next     = op_kind_reg;
        word_mode_next   = word_mode_reg;
        going_down_next  = going_down_reg;
        count_next       = count_reg;
        src_index_next   = src_index_reg;
        dst_index_next   = dst_index_reg;
        src_segment_next = src_segment_reg;
        dst_segment_next = dst_segment_reg;
        acc_next         = acc_reg;

        d1      = word_mode_reg ? head_data.item.first_data
                                : {8'h00, head_data.item.first_data[7:0]};
        d2      = word_mode_reg ? head_data.item.second_data
                                : {8'h00, head_data.item.second_data[7:0]};
        step    = word_mode_reg ? 16'd2 : 16'd1;
        if (going_down_reg)
        begin
            step = 16'(16'd0 - step);
        end
        is_cmp  = (op_kind_reg == OP_REPE_CMPS) || (op_kind_reg == OP_REPNE_CMPS);
        is_scas = (op_kind_reg == OP_REPE_SCAS) || (op_kind_reg == OP_REPNE_SCAS);
        is_repe = (op_kind_reg == OP_REPE_CMPS) || (op_kind_reg == OP_REPE_SCAS);

        // compare subtract
        cmp_a = is_cmp ? d1 : (word_mode_reg ? acc_reg : {8'h00, acc_reg[7:0]});
        diff  = {1'b0, cmp_a} - {1'b0, d2};
        cf    = word_mode_reg ? diff[16] : diff[8];
        af    = cmp_a[4] ^ d2[4] ^ diff[4];
        pf    = ~^diff[7:0];
        zf    = word_mode_reg ? (diff[15:0] == 16'd0) : (diff[7:0] == 8'd0);
        sf    = word_mode_reg ? diff[15] : diff[7];
        ovf   = word_mode_reg ? ((cmp_a[15] ^ diff[15]) & (cmp_a[15] ^ d2[15]))
                              : ((cmp_a[7] ^ diff[7]) & (cmp_a[7] ^ d2[7]));
        flags = {sf, zf, 1'b0, af, 1'b0, pf, 1'b0, cf};

        store = 16'd0;
        st_en = 1'b0;
        fin   = 1'b0;
        susp  = 1'b0;

        if (head_data.is_start)
        begin
            op_kind_next     = head_data.item.string_op;
            word_mode_next   = head_data.item.word_size;
            going_down_next  = head_data.item.direction_down;
            count_next       = head_data.item.start_count;
            src_index_next   = head_data.item.source_offset;
            dst_index_next   = head_data.item.dest_offset;
            src_segment_next = head_data.item.source_base;
            dst_segment_next = head_data.item.dest_base;
            acc_next         = head_data.item.first_data;
            busy_next        = !head_data.zero_run;
            fin              = head_data.zero_run;
            flags            = 8'h00;
            ovf              = 1'b0;
        end
        else
        begin
            case (op_kind_reg)
                OP_INS, OP_OUTS, OP_MOVS:
                begin
                    store = d1;
                    st_en = 1'b1;
                end
                OP_LODS:
                begin
                    acc_next = word_mode_reg ? d1 : {acc_reg[15:8], d1[7:0]};
                end
                OP_STOS:
                begin
                    store = word_mode_reg ? acc_reg : {8'h00, acc_reg[7:0]};
                    st_en = 1'b1;
                end
                default:
                begin
                    store = 16'd0;
                end
            endcase
            if (!(is_cmp || is_scas))
            begin
                flags = 8'h00;
                ovf   = 1'b0;
            end
            if ((op_kind_reg == OP_OUTS) || (op_kind_reg == OP_MOVS)
                || (op_kind_reg == OP_LODS) || is_cmp)
            begin
                src_index_next = src_index_reg + step;
            end
            if ((op_kind_reg == OP_INS) || (op_kind_reg == OP_MOVS)
                || (op_kind_reg == OP_STOS) || is_cmp || is_scas)
            begin
                dst_index_next = dst_index_reg + step;
            end
            count_next = count_reg - 16'd1;
            if (count_next == 16'd0)
            begin
                fin = 1'b1;
            end
            else if (is_cmp || is_scas)
            begin
                fin = is_repe ? !zf : zf;
            end
            else if ((op_kind_reg == OP_MOVS) || (op_kind_reg == OP_LODS)
                     || (op_kind_reg == OP_STOS))
            begin
                susp = head_data.item.budget_spent;
            end
            if (fin || susp)
            begin
                busy_next = 1'b0;
            end
        end

        src_sum = {1'b0, src_segment_next} + {9'd0, src_index_next};
        dst_sum = {1'b0, dst_segment_next} + {9'd0, dst_index_next};

        result_next.source_address    = (op_kind_next == OP_INS) ? {8'h00, src_index_next}
                                        : (src_sum[ADDR_W-1:0] & ADDR_MASK);
        result_next.dest_address      = (op_kind_next == OP_OUTS) ? {8'h00, dst_index_next}
                                        : (dst_sum[ADDR_W-1:0] & ADDR_MASK);
        result_next.store_data        = store;
        result_next.store_enable      = st_en;
        result_next.status_flags      = flags;
        result_next.overflow_flag     = ovf;
        result_next.count_left        = count_next;
        result_next.source_offset_now = src_index_next;
        result_next.dest_offset_now   = dst_index_next;
        result_next.accumulator_now   = acc_next;
        result_next.finished          = fin;
        result_next.suspended         = susp;
    end

    always_comb
    begin
        if (pop && produce)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            op_kind_reg      <= '0;
            word_mode_reg    <= 1'b0;
            going_down_reg   <= 1'b0;
            count_reg        <= '0;
            src_index_reg    <= '0;
            dst_index_reg    <= '0;
            src_segment_reg  <= '0;
            dst_segment_reg  <= '0;
            acc_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (pop && produce)
            begin
                busy_reg        <= busy_next;
                op_kind_reg     <= op_kind_next;
                word_mode_reg   <= word_mode_next;
                going_down_reg  <= going_down_next;
                count_reg       <= count_next;
                src_index_reg   <= src_index_next;
                dst_index_reg   <= dst_index_next;
                src_segment_reg <= src_segment_next;
                dst_segment_reg <= dst_segment_next;
                acc_reg         <= acc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && produce)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_fin_susp_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg |-> !(result_reg.finished && result_reg.suspended))
        else $error("finished and suspended both set");

    a_empty_start_idles: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && head_data.is_start && head_data.zero_run) |=> !busy_reg)
        else $error("empty run left sequencer busy");

    a_store_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && result_reg.store_enable) |-> (result_reg.status_flags == 8'h00))
        else $error("flags set on a storing beat");

endmodule

[hdl/rep_string_op_sequencer_unit.sv]
// a beat taken is first written into the queue, then its result is registered in the back end
// throughput: one beat per cycle while result_stall does not hold the result, set by the element step in the back end
// a two-entry queue between front and back lets input and output stall independently
// element beats arriving while no instruction runs are consumed without a result
// reset: asynchronous active-low rst_n clears the queue, the sequencer state and result valid
module rep_string_op_sequencer_unit #(
    parameter int ADDR_BITS = rsos_pkg::ADDR_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_stall,
    input  rsos_pkg::in_item_t  item,
    output logic                result_valid,
    input  logic                result_stall,
    output rsos_pkg::out_item_t result
);
    import rsos_pkg::*;

    queue_item_t entry;
    queue_item_t head_data;
    logic        full;
    logic        push;
    logic        pop;
    logic        head_valid;

    assign item_stall = full;
    assign push       = item_valid && !full;

    rsos_front u_front (
        .item  (item),
        .entry (entry)
    );

    rsos_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    rsos_back #(
        .ADDR_BITS (ADDR_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_data    (head_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
